>>> rtl/scs_pkg.sv
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types and constants of the shortest clause selector.
// ----------------------------------------------------------------------------
`default_nettype none

package scs_pkg;

    // Default sizes of the block
    localparam int MAX_LITERALS_DEF   = 1024;
    localparam int MAX_CLAUSES_DEF    = 4096;
    localparam int MAX_CLAUSE_LEN_DEF = 64;

    // Fixed field widths of the item and result transactions
    localparam int LIT_W    = 10;
    localparam int DEG_W    = 13;
    localparam int CLAUSE_W = 12;
    localparam int LEN_W    = 7;
    localparam int SUM_W    = 19;

    // Largest literal count the literal field can address
    localparam int LIT_SPAN = 1 << LIT_W;

    // Saturation value of a clause degree sum
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Item codes
    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,  // write one degree table entry
        MODE_LIT   = 2'd1,  // one literal of the open clause
        MODE_EMPTY = 2'd2,  // empty clause marker
        MODE_NOP   = 2'd3   // no effect
    } scs_mode_t;

    // Item as it travels from the read stage into the update stage
    typedef struct packed {
        scs_mode_t mode;
        logic      lit_ok;      // literal lies inside the degree table
        logic      clause_end;
        logic      set_end;
    } scs_item_t;

endpackage : scs_pkg

`default_nettype wire

>>> rtl/scs_in_if.sv
// ----------------------------------------------------------------------------
// scs_in_if
// Item channel: one degree load, clause literal or marker per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface scs_in_if import scs_pkg::*; ();

    logic                 valid;
    logic                 ready;
    scs_mode_t            mode;
    logic [LIT_W-1:0]     literal_index;
    logic [DEG_W-1:0]     degree_value;
    logic                 clause_end;
    logic                 set_end;

    modport source (
        output valid, mode, literal_index, degree_value, clause_end, set_end,
        input  ready
    );

    modport sink (
        input  valid, mode, literal_index, degree_value, clause_end, set_end,
        output ready
    );

endinterface : scs_in_if

`default_nettype wire

>>> rtl/scs_out_if.sv
// ----------------------------------------------------------------------------
// scs_out_if
// Result channel: one selected clause per transaction, at the end of a set.
// ----------------------------------------------------------------------------
`default_nettype none

interface scs_out_if import scs_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic [CLAUSE_W-1:0]  best_clause;
    logic [LEN_W-1:0]     best_length;
    logic [SUM_W-1:0]     best_degree_sum;
    logic                 found;
    logic                 overflow;

    modport source (
        output valid, best_clause, best_length, best_degree_sum, found, overflow,
        input  ready
    );

    modport sink (
        input  valid, best_clause, best_length, best_degree_sum, found, overflow,
        output ready
    );

endinterface : scs_out_if

`default_nettype wire

>>> rtl/scs_degree_mem.sv
// ----------------------------------------------------------------------------
// scs_degree_mem
// Degree table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module scs_degree_mem import scs_pkg::*; #(
    parameter int DEPTH = MAX_LITERALS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [DEG_W-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [DEG_W-1:0] rd_data
);

    logic [DEG_W-1:0] mem [DEPTH];
    logic [DEG_W-1:0] rd_data_reg;

    // Write a loaded degree
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : scs_degree_mem

`default_nettype wire

>>> rtl/scs_select.sv
// ----------------------------------------------------------------------------
// scs_select
// Update stage: accumulate the open clause, compare it with the best clause
// on close, and hold the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module scs_select import scs_pkg::*; #(
    parameter int MAX_CLAUSES    = MAX_CLAUSES_DEF,
    parameter int MAX_CLAUSE_LEN = MAX_CLAUSE_LEN_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    input  wire scs_item_t        item,
    input  wire logic [DEG_W-1:0] deg_data,
    output logic                  ready,
    scs_out_if.source             results
);

    localparam int CW = $clog2(MAX_CLAUSES + 1);
    localparam int LW = $clog2(MAX_CLAUSE_LEN + 1);

    // Stage register
    logic             s1_v_reg;
    scs_item_t        s1_item_reg;

    // Clause state
    logic [CW-1:0]    cnt_reg,     cnt_next;
    logic [LW-1:0]    cur_len_reg, cur_len_next;
    logic [SUM_W-1:0] cur_sum_reg, cur_sum_next;
    logic [CW-1:0]    best_idx_reg, best_idx_next;
    logic [LW-1:0]    best_len_reg, best_len_next;
    logic [SUM_W-1:0] best_sum_reg, best_sum_next;
    logic             have_reg,    have_next;
    logic             ovf_reg,     ovf_next;

    // Updated values before the end-of-set clear
    logic [CW-1:0]    cnt_u, idx_u;
    logic [LW-1:0]    len_u, blen_u;
    logic [SUM_W-1:0] sum_u, bsum_u;
    logic             have_u, ovf_u;
    logic             close;
    logic             emit;
    logic             fire;
    logic [DEG_W-1:0] deg;
    logic [SUM_W:0]   sum_w;
    logic [31:0]      idx_ext, len_ext;

    // Output register
    logic                out_v_reg;
    logic [CLAUSE_W-1:0] out_clause_reg;
    logic [LEN_W-1:0]    out_len_reg;
    logic [SUM_W-1:0]    out_sum_reg;
    logic                out_found_reg;
    logic                out_ovf_reg;

    // Advance the stage unless a result would overwrite one still waiting
    assign emit  = s1_item_reg.set_end &&
                   (s1_item_reg.mode == MODE_LIT || s1_item_reg.mode == MODE_EMPTY);
    assign fire  = s1_v_reg && (!emit || !out_v_reg || results.ready);
    assign ready = !s1_v_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (ready)
        begin
            s1_v_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && ready)
        begin
            s1_item_reg <= item;
        end
    end

    // Accumulate the literal and close the clause
    always_comb
    begin
        deg     = '0;
        sum_w   = '0;
        len_u   = cur_len_reg;
        sum_u   = cur_sum_reg;
        ovf_u   = ovf_reg;
        cnt_u   = cnt_reg;
        idx_u   = best_idx_reg;
        blen_u  = best_len_reg;
        bsum_u  = best_sum_reg;
        have_u  = have_reg;
        close   = 1'b0;

        case (s1_item_reg.mode)
            MODE_LIT:
            begin
                if (cur_len_reg < LW'(MAX_CLAUSE_LEN))
                begin
                    deg   = s1_item_reg.lit_ok ? deg_data : '0;
                    sum_w = {1'b0, cur_sum_reg} + (SUM_W + 1)'(deg);
                    sum_u = sum_w[SUM_W] ? SUM_MAX : sum_w[SUM_W-1:0];
                    len_u = cur_len_reg + LW'(1);
                end
                else
                begin
                    ovf_u = 1'b1;
                end
                close = s1_item_reg.clause_end || s1_item_reg.set_end;
            end
            MODE_EMPTY:
            begin
                close = 1'b1;
            end
            default:
            begin
                close = 1'b0;
            end
        endcase

        if (close)
        begin
            if (cnt_reg >= CW'(MAX_CLAUSES))
            begin
                ovf_u = 1'b1;
            end
            else
            begin
                if (len_u != '0 && (!have_reg || len_u < best_len_reg ||
                    (len_u == best_len_reg && sum_u > best_sum_reg)))
                begin
                    idx_u  = cnt_reg;
                    blen_u = len_u;
                    bsum_u = sum_u;
                    have_u = 1'b1;
                end
                cnt_u = cnt_reg + CW'(1);
            end
            len_u = '0;
            sum_u = '0;
        end

        // Clear the clause state at the end of the set
        cnt_next      = emit ? '0 : cnt_u;
        cur_len_next  = emit ? '0 : len_u;
        cur_sum_next  = emit ? '0 : sum_u;
        best_idx_next = emit ? '0 : idx_u;
        best_len_next = emit ? '0 : blen_u;
        best_sum_next = emit ? '0 : bsum_u;
        have_next     = emit ? 1'b0 : have_u;
        ovf_next      = emit ? 1'b0 : ovf_u;

        idx_ext = 32'(idx_u);
        len_ext = 32'(blen_u);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            cur_len_reg  <= '0;
            cur_sum_reg  <= '0;
            best_idx_reg <= '0;
            best_len_reg <= '0;
            best_sum_reg <= '0;
            have_reg     <= 1'b0;
            ovf_reg      <= 1'b0;
        end
        else if (fire)
        begin
            cnt_reg      <= cnt_next;
            cur_len_reg  <= cur_len_next;
            cur_sum_reg  <= cur_sum_next;
            best_idx_reg <= best_idx_next;
            best_len_reg <= best_len_next;
            best_sum_reg <= best_sum_next;
            have_reg     <= have_next;
            ovf_reg      <= ovf_next;
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (fire && emit)
        begin
            out_v_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            out_clause_reg <= have_u ? idx_ext[CLAUSE_W-1:0] : '0;
            out_len_reg    <= have_u ? len_ext[LEN_W-1:0] : '0;
            out_sum_reg    <= have_u ? bsum_u : '0;
            out_found_reg  <= have_u;
            out_ovf_reg    <= ovf_u;
        end
    end

    assign results.valid           = out_v_reg;
    assign results.best_clause     = out_clause_reg;
    assign results.best_length     = out_len_reg;
    assign results.best_degree_sum = out_sum_reg;
    assign results.found           = out_found_reg;
    assign results.overflow        = out_ovf_reg;

    // Open clause never grows past its capacity
    a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cur_len_reg <= LW'(MAX_CLAUSE_LEN))
        else $error("open clause length beyond capacity");

    // Clause count never passes the capacity
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_CLAUSES))
        else $error("clause counter beyond capacity");

    // A kept clause is never empty
    a_best_len: assert property (@(posedge clk) disable iff (!rst_n)
        have_reg |-> best_len_reg != '0)
        else $error("best clause recorded with zero length");

    // Emitting a result clears the clause state
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        fire && emit |=> cnt_reg == '0 && !have_reg && !ovf_reg)
        else $error("clause state not cleared after result");

    // A not-found result carries zero fields
    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && !out_found_reg |-> out_clause_reg == '0 && out_len_reg == '0)
        else $error("not-found result with nonzero fields");

endmodule : scs_select

`default_nettype wire

>>> rtl/shortest_clause_selector_top.sv
// ----------------------------------------------------------------------------
// shortest_clause_selector_top
// Shortest clause branching selector: degree table load, clause streaming,
// one result per clause set.
// ----------------------------------------------------------------------------
//  channel  | direction | transaction
//  items    | sink      | degree load, clause literal or empty clause marker
//  results  | source    | selected clause, length, degree sum, found, overflow
//
//  One item per cycle unless the update stage stalls. An item reads the
//  degree table when it is accepted and updates the clause state when it
//  leaves the stage register; a set-end item then fills the output register.
//  Reset clears the clause state at once; the degree table needs no clearing.
//  A result waits in the output register; items keep flowing until a second
//  result finds that register still full and not taken; the stage stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module shortest_clause_selector_top import scs_pkg::*; #(
    parameter int MAX_LITERALS   = MAX_LITERALS_DEF,
    parameter int MAX_CLAUSES    = MAX_CLAUSES_DEF,
    parameter int MAX_CLAUSE_LEN = MAX_CLAUSE_LEN_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    scs_in_if.sink    items,
    scs_out_if.source results
);

    // Only the entries the literal field can reach are stored
    localparam int DEPTH = (MAX_LITERALS < LIT_SPAN) ? MAX_LITERALS : LIT_SPAN;
    localparam int AW    = $clog2(DEPTH);

    logic             accept;
    logic             lit_ok;
    logic [AW-1:0]    addr;
    logic [DEG_W-1:0] deg_data;
    scs_item_t        item;

    // Decode the item for the table and the update stage
    assign accept = items.valid && items.ready;
    assign lit_ok = 32'(items.literal_index) < 32'(MAX_LITERALS);
    assign addr   = items.literal_index[AW-1:0];

    assign item.mode       = items.mode;
    assign item.lit_ok     = lit_ok;
    assign item.clause_end = items.clause_end;
    assign item.set_end    = items.set_end;

    scs_degree_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (accept && items.mode == MODE_LOAD && lit_ok),
        .wr_addr (addr),
        .wr_data (items.degree_value),
        .rd_en   (accept),
        .rd_addr (addr),
        .rd_data (deg_data)
    );

    scs_select #(
        .MAX_CLAUSES    (MAX_CLAUSES),
        .MAX_CLAUSE_LEN (MAX_CLAUSE_LEN)
    ) u_select (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (items.valid),
        .item       (item),
        .deg_data   (deg_data),
        .ready      (items.ready),
        .results    (results)
    );

endmodule : shortest_clause_selector_top

`default_nettype wire

>>> tb/tb_shortest_clause_selector_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_shortest_clause_selector_top
// Self-checking bench for the shortest clause selector. A short table of
// directed items covers the corner cases (reset, extremes, ties, markers,
// set end without clause end, ignored items). Random clause sets follow,
// including over-long clauses. Every result is checked field by field
// against a behavioral predictor or a typed expectation from the table.
// ----------------------------------------------------------------------------

module tb_shortest_clause_selector_top import scs_pkg::*; ();

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 400;
    localparam int MAX_PRINTS     = 50;

    typedef struct packed {
        scs_mode_t          mode;
        logic [LIT_W-1:0]   lit;
        logic [DEG_W-1:0]   deg;
        logic               cend;
        logic               send;
    } item_t;

    typedef struct packed {
        logic [CLAUSE_W-1:0] clause_idx;
        logic [LEN_W-1:0]    len;
        logic [SUM_W-1:0]    dsum;
        logic                found;
        logic                ovf;
    } pick_t;

    typedef struct {
        item_t it;
        bit    known;
        pick_t want;
    } dir_row_t;

    localparam pick_t NO_PICK = '0;

    logic clk;
    logic rst_n;

    scs_in_if  items_ch ();
    scs_out_if results_ch ();

    shortest_clause_selector_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_ch),
        .results (results_ch)
    );

    // Predictor state: degree table and the open set
    logic [DEG_W-1:0] deg_tbl [LIT_SPAN];
    int  clause_no;
    int  open_len;
    int  open_sum;
    int  best_no;
    int  best_len;
    int  best_sum;
    bit  have_best;
    bit  ovf_seen;

    pick_t    pending_picks [$];
    dir_row_t dir_rows [$];
    int       known_lits [$];
    bit       lit_loaded [LIT_SPAN];

    int errors;
    int items_sent;
    int results_seen;
    int ovf_results;
    int found_results;
    int long_clauses;
    int idle_cycles;
    int send_idle_pct;
    int recv_idle_pct;
    int stall_request;
    int hold_left;

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Close the open clause and let it compete for the best slot
    function automatic void close_open_clause();
        if (clause_no >= MAX_CLAUSES_DEF) begin
            ovf_seen = 1'b1;
        end
        else begin
            if (open_len > 0 && (!have_best || open_len < best_len ||
                (open_len == best_len && open_sum > best_sum))) begin
                best_no   = clause_no;
                best_len  = open_len;
                best_sum  = open_sum;
                have_best = 1'b1;
            end
            clause_no++;
        end
        open_len = 0;
        open_sum = 0;
    endfunction

    function automatic void clear_selection();
        clause_no = 0;
        open_len  = 0;
        open_sum  = 0;
        best_no   = 0;
        best_len  = 0;
        best_sum  = 0;
        have_best = 1'b0;
        ovf_seen  = 1'b0;
    endfunction

    // Advance the predictor by one accepted item; return 1 with a result
    function automatic bit select_step(input item_t it, output pick_t res);
        int s;
        res = '0;
        case (it.mode)
            MODE_LOAD:
            begin
                deg_tbl[it.lit] = it.deg;
                return 1'b0;
            end
            MODE_NOP:
            begin
                return 1'b0;
            end
            MODE_LIT:
            begin
                if (open_len < MAX_CLAUSE_LEN_DEF) begin
                    s = open_sum + int'(deg_tbl[it.lit]);
                    open_sum = (s > int'(SUM_MAX)) ? int'(SUM_MAX) : s;
                    open_len++;
                end
                else begin
                    ovf_seen = 1'b1;
                end
                if (it.cend || it.send)
                    close_open_clause();
            end
            default:
            begin
                close_open_clause();
            end
        endcase
        if (!it.send)
            return 1'b0;
        if (have_best) begin
            res.clause_idx = best_no[CLAUSE_W-1:0];
            res.len        = best_len[LEN_W-1:0];
            res.dsum       = best_sum[SUM_W-1:0];
            res.found      = 1'b1;
        end
        res.ovf = ovf_seen;
        clear_selection();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic item_t mk(scs_mode_t m, int lit, int deg, bit ce, bit se);
        item_t it;
        it.mode = m;
        it.lit  = lit[LIT_W-1:0];
        it.deg  = deg[DEG_W-1:0];
        it.cend = ce;
        it.send = se;
        return it;
    endfunction

    function automatic pick_t mk_pick(int c, int l, int s, bit f, bit o);
        pick_t p;
        p.clause_idx = c[CLAUSE_W-1:0];
        p.len        = l[LEN_W-1:0];
        p.dsum       = s[SUM_W-1:0];
        p.found      = f;
        p.ovf        = o;
        return p;
    endfunction

    // Track table entries that hold a degree, so literals only read those
    function automatic void note_loaded(int lit);
        if (!lit_loaded[lit]) begin
            lit_loaded[lit] = 1'b1;
            known_lits.push_back(lit);
        end
    endfunction

    function automatic int rand_degree();
        case ($urandom_range(9))
            0:       return 0;
            1:       return (1 << DEG_W) - 1;
            2:       return 4096;
            3, 4, 5: return $urandom_range(0, 3);
            default: return $urandom_range(0, (1 << DEG_W) - 1);
        endcase
    endfunction

    function automatic int pick_lit();
        return known_lits[$urandom_range(known_lits.size() - 1)];
    endfunction

    // Offer one transaction on the item channel; predict once accepted
    task automatic offer_item(input item_t it, input bit known, input pick_t want);
        pick_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            items_ch.valid <= 1'b0;
            @(negedge clk);
        end
        items_ch.mode          <= it.mode;
        items_ch.literal_index <= it.lit;
        items_ch.degree_value  <= it.deg;
        items_ch.clause_end    <= it.cend;
        items_ch.set_end       <= it.send;
        items_ch.valid         <= 1'b1;
        @(posedge clk);
        while (!items_ch.ready)
            @(posedge clk);
        if (it.mode != MODE_NOP)
            items_sent++;
        if (select_step(it, res))
            pending_picks.push_back(known ? want : res);
        @(negedge clk);
    endtask

    // One clause set with random content, occasional noise and broken forms
    task automatic send_random_set();
        int  n_cl;
        int  len;
        int  style;
        int  r;
        int  l;
        bit  last;
        bit  tail;
        n_cl = $urandom_range(1, 6);
        if ($urandom_range(99) < 30) begin
            repeat ($urandom_range(1, 8)) begin
                l = $urandom_range(0, LIT_SPAN - 1);
                note_loaded(l);
                offer_item(mk(MODE_LOAD, l, rand_degree(), $urandom_range(1),
                              $urandom_range(1)), 1'b0, NO_PICK);
            end
        end
        for (int c = 0; c < n_cl; c++) begin
            last = (c == n_cl - 1);
            // drop in an ignored item now and then
            if ($urandom_range(99) < 4)
                offer_item(mk(MODE_NOP, $urandom_range(0, LIT_SPAN - 1), rand_degree(),
                              $urandom_range(1), $urandom_range(1)), 1'b0, NO_PICK);
            // reload a degree inside the set
            if ($urandom_range(99) < 5) begin
                l = $urandom_range(0, LIT_SPAN - 1);
                note_loaded(l);
                offer_item(mk(MODE_LOAD, l, rand_degree(), $urandom_range(1), 1'b0),
                           1'b0, NO_PICK);
            end
            r = $urandom_range(99);
            if (r < 18) begin
                offer_item(mk(MODE_EMPTY, $urandom_range(0, LIT_SPAN - 1), rand_degree(),
                              $urandom_range(1), last), 1'b0, NO_PICK);
            end
            else begin
                r = $urandom_range(99);
                if (r < 85)
                    len = $urandom_range(1, 4);
                else if (r < 95)
                    len = $urandom_range(5, 12);
                else
                    len = $urandom_range(MAX_CLAUSE_LEN_DEF - 4, MAX_CLAUSE_LEN_DEF + 8);
                if (len > MAX_CLAUSE_LEN_DEF)
                    long_clauses++;
                // 0: normal close, 1: closed by a marker, 2: set end without clause end
                style = $urandom_range(99);
                style = (style < 10) ? 1 : (style < 25 && last) ? 2 : 0;
                for (int k = 0; k < len; k++) begin
                    tail = (k == len - 1);
                    offer_item(mk(MODE_LIT, pick_lit(), rand_degree(),
                                  tail && style == 0, tail && last && style != 1),
                               1'b0, NO_PICK);
                end
                if (style == 1)
                    offer_item(mk(MODE_EMPTY, $urandom_range(0, LIT_SPAN - 1),
                                  rand_degree(), $urandom_range(1), last), 1'b0, NO_PICK);
            end
        end
    endtask

    // Pause the sender until every expected result is back
    task automatic finish_phase();
        items_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_picks.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic report_miss(input string what, input int got, input int want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("[%0t] mismatch on result %0d: %s got %0d expected %0d",
                     $realtime, results_seen, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls plus one long hold-off on request
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (stall_request > 0) begin
            hold_left = stall_request;
            stall_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            results_ch.ready <= 1'b0;
        end
        else begin
            results_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result check: compare each transaction with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk) begin : check_results
        pick_t want;
        if (rst_n && results_ch.valid && results_ch.ready) begin
            results_seen++;
            if (pending_picks.size() == 0) begin
                report_miss("unexpected result, best_clause", results_ch.best_clause, 0);
            end
            else begin
                want = pending_picks.pop_front();
                if (results_ch.best_clause !== want.clause_idx)
                    report_miss("best_clause", results_ch.best_clause, want.clause_idx);
                if (results_ch.best_length !== want.len)
                    report_miss("best_length", results_ch.best_length, want.len);
                if (results_ch.best_degree_sum !== want.dsum)
                    report_miss("best_degree_sum", results_ch.best_degree_sum, want.dsum);
                if (results_ch.found !== want.found)
                    report_miss("found", results_ch.found, want.found);
                if (results_ch.overflow !== want.ovf)
                    report_miss("overflow", results_ch.overflow, want.ovf);
                if (want.ovf)
                    ovf_results++;
                if (want.found)
                    found_results++;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk) begin
        if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, pending_picks.size());
            $display("tb_shortest_clause_selector_top: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int stop_at;
        bit hold_done;

        rst_n                  = 1'b0;
        items_ch.valid         = 1'b0;
        items_ch.mode          = MODE_NOP;
        items_ch.literal_index = '0;
        items_ch.degree_value  = '0;
        items_ch.clause_end    = 1'b0;
        items_ch.set_end       = 1'b0;
        results_ch.ready       = 1'b0;
        errors        = 0;
        items_sent    = 0;
        results_seen  = 0;
        ovf_results   = 0;
        found_results = 0;
        long_clauses  = 0;
        idle_cycles   = 0;
        stall_request = 0;
        hold_left     = 0;
        hold_done     = 1'b0;
        send_idle_pct = 17;
        recv_idle_pct = 67;
        foreach (deg_tbl[i])
            deg_tbl[i] = '0;
        foreach (lit_loaded[i])
            lit_loaded[i] = 1'b0;
        clear_selection();

        // Directed table: typed expectations where they are obvious
        dir_rows.push_back(dir_row_t'{mk(MODE_EMPTY, 0, 0, 1'b0, 1'b1), 1'b1,
                                      mk_pick(0, 0, 0, 1'b0, 1'b0)});
        dir_rows.push_back(dir_row_t'{mk(MODE_LOAD, 0, 0, 1'b0, 1'b0), 1'b0, NO_PICK});
        dir_rows.push_back(dir_row_t'{mk(MODE_LOAD, 1023, 8191, 1'b1, 1'b0), 1'b0, NO_PICK});
        dir_rows.push_back(dir_row_t'{mk(MODE_LOAD, 1, 4096, 1'b0, 1'b0), 1'b0, NO_PICK});
        dir_rows.push_back(dir_row_t'{mk(MODE_LOAD, 2, 1, 1'b0, 1'b1), 1'b0, NO_PICK});
        dir_rows.push_back(dir_row_t'{mk(MODE_NOP, 1023, 8191, 1'b1, 1'b1), 1'b0, NO_PICK});
        dir_rows.push_back(dir_row_t'{mk(MODE_LIT, 1023, 0, 1'b1, 1'b1), 1'b1,
                                      mk_pick(0, 1, 8191, 1'b1, 1'b0)});
        dir_rows.push_back(dir_row_t'{mk(MODE_LIT, 1, 8191, 1'b0, 1'b0), 1'b0, NO_PICK});
        dir_rows.push_back(dir_row_t'{mk(MODE_LIT, 1023, 0, 1'b1, 1'b0), 1'b0, NO_PICK});
        dir_rows.push_back(dir_row_t'{mk(MODE_LIT, 0, 0, 1'b1, 1'b0), 1'b0, NO_PICK});
        dir_rows.push_back(dir_row_t'{mk(MODE_LIT, 2, 0, 1'b1, 1'b0), 1'b0, NO_PICK});
        dir_rows.push_back(dir_row_t'{mk(MODE_LIT, 2, 0, 1'b1, 1'b0), 1'b0, NO_PICK});
        dir_rows.push_back(dir_row_t'{mk(MODE_EMPTY, 1023, 8191, 1'b1, 1'b1), 1'b0, NO_PICK});
        dir_rows.push_back(dir_row_t'{mk(MODE_LIT, 1, 0, 1'b0, 1'b0), 1'b0, NO_PICK});
        dir_rows.push_back(dir_row_t'{mk(MODE_EMPTY, 0, 0, 1'b0, 1'b0), 1'b0, NO_PICK});
        dir_rows.push_back(dir_row_t'{mk(MODE_EMPTY, 0, 0, 1'b0, 1'b0), 1'b0, NO_PICK});
        dir_rows.push_back(dir_row_t'{mk(MODE_LIT, 0, 0, 1'b0, 1'b1), 1'b0, NO_PICK});
        dir_rows.push_back(dir_row_t'{mk(MODE_LOAD, 1, 7, 1'b0, 1'b0), 1'b0, NO_PICK});
        dir_rows.push_back(dir_row_t'{mk(MODE_LIT, 1, 0, 1'b1, 1'b1), 1'b1,
                                      mk_pick(0, 1, 7, 1'b1, 1'b0)});
        dir_rows.push_back(dir_row_t'{mk(MODE_EMPTY, 0, 0, 1'b0, 1'b0), 1'b0, NO_PICK});
        dir_rows.push_back(dir_row_t'{mk(MODE_EMPTY, 0, 0, 1'b0, 1'b1), 1'b1,
                                      mk_pick(0, 0, 0, 1'b0, 1'b0)});

        // Hold reset, then release it on a falling edge
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed table
        foreach (dir_rows[i]) begin
            if (dir_rows[i].it.mode == MODE_LOAD)
                note_loaded(dir_rows[i].it.lit);
            offer_item(dir_rows[i].it, dir_rows[i].known, dir_rows[i].want);
        end

        // Random sets: slow receiver, with one long hold-off mid-phase
        stop_at = items_sent + 800;
        while (items_sent < stop_at) begin
            if (!hold_done && items_sent >= stop_at - 500) begin
                stall_request = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            send_random_set();
        end
        finish_phase();

        // Random sets: slow sender
        send_idle_pct = 67;
        recv_idle_pct = 17;
        stop_at = items_sent + 400;
        while (items_sent < stop_at)
            send_random_set();
        finish_phase();

        // Full rate: random sets back to back
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stop_at = items_sent + 400;
        while (items_sent < stop_at)
            send_random_set();
        finish_phase();

        $display("covered %0d item transactions and %0d results (%0d found, %0d overflow)",
                 items_sent, results_seen, found_results, ovf_results);
        $display("including %0d over-long clauses and one long result hold-off",
                 long_clauses);
        if (errors == 0)
            $display("tb_shortest_clause_selector_top: PASS");
        else
            $display("tb_shortest_clause_selector_top: FAIL");
        $finish;
    end

endmodule

>>> shortest_clause_selector_top.f
rtl/scs_pkg.sv
rtl/scs_in_if.sv
rtl/scs_out_if.sv
rtl/scs_degree_mem.sv
rtl/scs_select.sv
rtl/shortest_clause_selector_top.sv
tb/tb_shortest_clause_selector_top.sv
